// ===== design/mqr_pkg.sv =====
package mqr_pkg;

  localparam int MQR_MAX_DIM    = 8;
  localparam int MQR_DATA_WIDTH = 32;

  localparam int CFG_W       = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int VALUE_W     = 32;
  localparam int ANGLE_W     = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 1'd1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ROTATE = 1'b1;

  localparam logic [ANGLE_W-1:0] ANGLE_INVALID = 2'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_90      = 2'd1;
  localparam logic [ANGLE_W-1:0] ANGLE_180     = 2'd2;
  localparam logic [ANGLE_W-1:0] ANGLE_270     = 2'd3;

  typedef struct packed {
    logic                       command;
    logic signed [VALUE_W-1:0]  element_value;
    logic [ANGLE_W-1:0]         angle_code;
  } mqr_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  out_value;
    logic                       last_of_run;
    logic                       angle_error;
  } mqr_out_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
  } mqr_cmd_t;

  typedef struct packed {
    logic can_issue;
    logic at_end;
  } mqr_status_t;

endpackage

// ===== design/mqr_ram.sv =====
module mqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mqr_ctrl.sv =====
module mqr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  mqr_pkg::mqr_status_t status,
  output mqr_pkg::mqr_cmd_t    cmd
);
  import mqr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (status.can_issue) begin
          cmd.step = 1'b1;
          if (status.at_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/mqr_datapath.sv =====
module mqr_datapath #(
  parameter int MAX_DIM    = mqr_pkg::MQR_MAX_DIM,
  parameter int DATA_WIDTH = mqr_pkg::MQR_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mqr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mqr_pkg::CFG_W-1:0]       cfg_data,
  input  mqr_pkg::mqr_in_t                in_data,
  input  mqr_pkg::mqr_cmd_t               cmd,
  output mqr_pkg::mqr_status_t            status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mqr_pkg::mqr_out_t               out_data
);
  import mqr_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * DIM_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  logic [CFG_W-1:0]   row_count_r;
  logic [CFG_W-1:0]   col_count_r;
  logic [ADDR_W-1:0]  load_pos_r;
  logic [ADDR_W-1:0]  load_pos_nxt;
  logic [ANGLE_W-1:0] angle_r;
  logic [DIM_W-1:0]   i_r;
  logic [DIM_W-1:0]   j_r;
  logic               pend_r;
  logic               pend_last_r;
  logic               pend_err_r;
  logic               out_valid_r;
  mqr_out_t           out_data_r;

  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   cols;
  logic [PROD_W-1:0]  total;
  logic [DIM_W-1:0]   out_rows;
  logic [DIM_W-1:0]   out_cols;
  logic [DIM_W-1:0]   src_r;
  logic [DIM_W-1:0]   src_c;
  logic [PROD_W-1:0]  row_base;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic               err_angle;
  logic               last_elem;
  logic               pend_move;
  logic               rd_en;

  assign rows     = clamp_dim(row_count_r);
  assign cols     = clamp_dim(col_count_r);
  assign total    = {{DIM_W{1'b0}}, rows} * {{DIM_W{1'b0}}, cols};
  assign out_rows = (angle_r == ANGLE_180) ? rows : cols;
  assign out_cols = (angle_r == ANGLE_180) ? cols : rows;

  always_comb begin
    unique case (angle_r)
      ANGLE_90: begin
        src_r = rows - DIM_W'(1) - j_r;
        src_c = i_r;
      end
      ANGLE_180: begin
        src_r = rows - DIM_W'(1) - i_r;
        src_c = cols - DIM_W'(1) - j_r;
      end
      ANGLE_270: begin
        src_r = j_r;
        src_c = cols - DIM_W'(1) - i_r;
      end
      default: begin
        src_r = '0;
        src_c = '0;
      end
    endcase
  end

  assign row_base = {{DIM_W{1'b0}}, src_r} * {{DIM_W{1'b0}}, cols};
  assign rd_addr  = ADDR_W'(row_base + PROD_W'(src_c));

  assign err_angle = (angle_r == ANGLE_INVALID);
  assign last_elem = (i_r == out_rows - DIM_W'(1)) && (j_r == out_cols - DIM_W'(1));
  assign pend_move = pend_r && (!out_valid_r || out_ready);
  assign rd_en     = cmd.step && !err_angle;

  assign status.can_issue = !pend_r || pend_move;
  assign status.at_end    = err_angle || last_elem;

  always_comb begin
    load_pos_nxt = load_pos_r + ADDR_W'(1);
    if (PROD_W'(load_pos_nxt) >= total || load_pos_nxt == '0) begin
      load_pos_nxt = '0;
    end
  end

  mqr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (load_pos_r),
    .wdata (DATA_WIDTH'($unsigned(in_data.element_value))),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_W'(1);
      col_count_r <= CFG_W'(1);
      load_pos_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_COUNT: row_count_r <= cfg_data;
          REG_COL_COUNT: col_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        load_pos_r <= load_pos_nxt;
      end
      if (cmd.step) begin
        pend_r <= 1'b1;
      end else if (pend_move) begin
        pend_r <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      angle_r <= in_data.angle_code;
      i_r     <= '0;
      j_r     <= '0;
    end else if (rd_en) begin
      if (j_r == out_cols - DIM_W'(1)) begin
        j_r <= '0;
        i_r <= i_r + DIM_W'(1);
      end else begin
        j_r <= j_r + DIM_W'(1);
      end
    end
    if (cmd.step) begin
      pend_last_r <= status.at_end;
      pend_err_r  <= err_angle;
    end
    if (pend_move) begin
      out_data_r.out_value   <= pend_err_r ? '0 : $signed(VALUE_W'(rd_data));
      out_data_r.last_of_run <= pend_last_r;
      out_data_r.angle_error <= pend_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/matrix_quarter_turn_rotator.sv =====
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     mqr_in_t: command, element_value, angle_code
// out_      output     out_valid / out_ready   mqr_out_t: out_value, last_of_run, angle_error
// cfg_      input      cfg_we                  cfg_index selects row_count or col_count
//
// A load word writes the store at the load position.
// A rotate word enters, then the store gives one result word per cycle unless
// out_ready stalls the output; the single read port of the store sets this rate.
// An invalid angle gives one error word.
// Reset is synchronous on rst_n; store contents are not cleared.
// A stall on out_ready stops reads of the store until the output register frees.
module matrix_quarter_turn_rotator #(
  parameter int MAX_DIM    = mqr_pkg::MQR_MAX_DIM,
  parameter int DATA_WIDTH = mqr_pkg::MQR_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mqr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mqr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mqr_pkg::mqr_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mqr_pkg::mqr_out_t               out_data
);
  import mqr_pkg::*;

  mqr_cmd_t    cmd;
  mqr_status_t status;

  mqr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  mqr_datapath #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/mqr_rotation_checker.sv =====
module mqr_rotation_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mqr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mqr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  mqr_pkg::mqr_in_t                in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  mqr_pkg::mqr_out_t               out_data,
  output int                              mismatch_count,
  output int unsigned                     words_pending
);
  import mqr_pkg::*;

  logic [VALUE_W-1:0] matrix_mem [MQR_MAX_DIM*MQR_MAX_DIM];
  logic [5:0]         load_pos;
  logic [CFG_W-1:0]   rows_reg;
  logic [CFG_W-1:0]   cols_reg;
  mqr_out_t           rotated_words [$];

  initial mismatch_count = 0;
  initial words_pending = 0;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MQR_MAX_DIM) return MQR_MAX_DIM;
    return raw;
  endfunction

  task automatic predict_rotation(mqr_in_t w);
    int unsigned rows;
    int unsigned cols;
    int unsigned total;
    int unsigned out_rows;
    int unsigned out_cols;
    int unsigned src_r;
    int unsigned src_c;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    mqr_out_t    res;
    rows  = eff_dim(rows_reg);
    cols  = eff_dim(cols_reg);
    total = rows * cols;
    if (w.command == CMD_LOAD) begin
      matrix_mem[load_pos] = w.element_value;
      if (load_pos + 1 >= total) begin
        load_pos = '0;
      end else begin
        load_pos = load_pos + 1'b1;
      end
    end else if (w.angle_code == ANGLE_INVALID) begin
      res.out_value   = '0;
      res.last_of_run = 1'b1;
      res.angle_error = 1'b1;
      rotated_words.push_back(res);
    end else begin
      out_rows = (w.angle_code == ANGLE_180) ? rows : cols;
      out_cols = (w.angle_code == ANGLE_180) ? cols : rows;
      k = 0;
      for (i = 0; i < out_rows; i++) begin
        for (j = 0; j < out_cols; j++) begin
          case (w.angle_code)
            ANGLE_90: begin
              src_r = rows - 1 - j;
              src_c = i;
            end
            ANGLE_180: begin
              src_r = rows - 1 - i;
              src_c = cols - 1 - j;
            end
            default: begin
              src_r = j;
              src_c = cols - 1 - i;
            end
          endcase
          res.out_value   = matrix_mem[src_r * cols + src_c];
          res.last_of_run = (k + 1 == total);
          res.angle_error = 1'b0;
          rotated_words.push_back(res);
          k++;
        end
      end
    end
  endtask

  task automatic compare_word(mqr_out_t got);
    mqr_out_t want;
    if (rotated_words.size() == 0) begin
      $display("%0t: result word with nothing expected, expected none, actual %p", $time, got);
      mismatch_count++;
    end else begin
      want = rotated_words.pop_front();
      if (got.out_value !== want.out_value) begin
        $display("%0t: out_value expected %0d, actual %0d", $time, want.out_value,
                 got.out_value);
        mismatch_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %b, actual %b", $time, want.last_of_run,
                 got.last_of_run);
        mismatch_count++;
      end
      if (got.angle_error !== want.angle_error) begin
        $display("%0t: angle_error expected %b, actual %b", $time, want.angle_error,
                 got.angle_error);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_reg = CFG_W'(1);
      cols_reg = CFG_W'(1);
      load_pos = '0;
      rotated_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT: rows_reg = cfg_data;
          REG_COL_COUNT: cols_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_rotation(in_data);
      end
      if (out_valid && out_ready) begin
        compare_word(out_data);
      end
    end
    words_pending <= rotated_words.size();
  end

endmodule

// ===== tb/tb_matrix_quarter_turn_rotator.sv =====
module tb_matrix_quarter_turn_rotator;
  import mqr_pkg::*;

  localparam int RANDOM_ITEMS  = 100;
  localparam int SETTLE_CYCLES = 8;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_ROW_COUNT;
  logic [CFG_W-1:0]       cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  mqr_in_t                in_data   = '0;
  logic                   out_ready = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  mqr_out_t               out_data;

  int                     mismatch_count;
  int unsigned            words_pending;
  bit                     no_idle = 1'b0;
  bit                     written [MQR_MAX_DIM*MQR_MAX_DIM];
  int unsigned            load_pos_shadow = 0;
  int unsigned            rows_eff = 1;
  int unsigned            cols_eff = 1;
  int                     words_sent = 0;

  always #4 clk = ~clk;

  matrix_quarter_turn_rotator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mqr_rotation_checker i_rotation_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 34);
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MQR_MAX_DIM) return MQR_MAX_DIM;
    return raw;
  endfunction

  task automatic set_dims(logic [CFG_W-1:0] rows_raw, logic [CFG_W-1:0] cols_raw);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= rows_raw;
    @(posedge clk);
    cfg_index <= REG_COL_COUNT;
    cfg_data  <= cols_raw;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_eff = eff_dim(rows_raw);
    cols_eff = eff_dim(cols_raw);
  endtask

  task automatic send_word(logic cmd, logic signed [VALUE_W-1:0] value,
                           logic [ANGLE_W-1:0] angle);
    mqr_in_t w;
    w.command       = cmd;
    w.element_value = value;
    w.angle_code    = angle;
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (cmd == CMD_LOAD) begin
      written[load_pos_shadow] = 1'b1;
      if (load_pos_shadow + 1 >= rows_eff * cols_eff) begin
        load_pos_shadow = 0;
      end else begin
        load_pos_shadow++;
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      phase_items;
    int unsigned      n;
    int unsigned      k;
    int               random_start;
    bit               store_full;
    logic [CFG_W-1:0] rows_raw;
    logic [CFG_W-1:0] cols_raw;
    logic [VALUE_W-1:0] value;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A 1x1 matrix at the reset dimensions, with both extreme values.
    send_word(CMD_LOAD, 32'sh8000_0000, ANGLE_270);
    send_word(CMD_ROTATE, 32'sh0, ANGLE_90);
    send_word(CMD_LOAD, 32'sh7fff_ffff, ANGLE_INVALID);
    send_word(CMD_ROTATE, 32'sh0, ANGLE_180);
    settle();

    // A 2x3 matrix turned every way, then a bad angle.
    set_dims(CFG_W'(2), CFG_W'(3));
    send_word(CMD_LOAD, -32'sd1, ANGLE_90);
    send_word(CMD_LOAD, 32'sd0, ANGLE_180);
    send_word(CMD_LOAD, 32'sd1, ANGLE_270);
    send_word(CMD_LOAD, 32'sh5555_5555, ANGLE_INVALID);
    send_word(CMD_LOAD, 32'shaaaa_aaaa, ANGLE_90);
    send_word(CMD_LOAD, 32'sh7fff_fffe, ANGLE_180);
    send_word(CMD_ROTATE, 32'sh1234_5678, ANGLE_90);
    send_word(CMD_ROTATE, 32'shffff_ffff, ANGLE_180);
    send_word(CMD_ROTATE, 32'sh0, ANGLE_270);
    send_word(CMD_ROTATE, 32'shffff_ffff, ANGLE_INVALID);
    for (k = 0; k < 4; k++) begin
      send_word(CMD_LOAD, $urandom(), ANGLE_W'($urandom_range(3)));
    end
    settle();

    // Shrinking the matrix leaves the load position past its end.
    set_dims(CFG_W'(1), CFG_W'(2));
    send_word(CMD_LOAD, 32'sh0bad_cafe, ANGLE_INVALID);
    send_word(CMD_ROTATE, 32'sh0, ANGLE_270);
    send_word(CMD_ROTATE, 32'sh0, ANGLE_90);

    random_start = words_sent;
    for (phase = 0; words_sent - random_start < RANDOM_ITEMS; phase++) begin
      settle();
      case (phase)
        0: begin
          rows_raw = CFG_W'($urandom_range(2, 4));
          cols_raw = CFG_W'($urandom_range(2, 4));
        end
        1: begin
          rows_raw = CFG_W'(0);
          cols_raw = CFG_W'(15);
        end
        2: begin
          rows_raw = CFG_W'(15);
          cols_raw = CFG_W'(0);
        end
        3: begin
          rows_raw = CFG_W'(8);
          cols_raw = CFG_W'(8);
        end
        default: begin
          if ($urandom_range(4) == 0) begin
            rows_raw = CFG_W'($urandom_range(15));
            cols_raw = CFG_W'($urandom_range(15));
          end else begin
            rows_raw = CFG_W'($urandom_range(1, 4));
            cols_raw = CFG_W'($urandom_range(1, 4));
          end
        end
      endcase
      set_dims(rows_raw, cols_raw);
      no_idle = (phase == 0);
      phase_items = rows_eff * cols_eff + ((phase == 0) ? 20 : $urandom_range(4, 12));
      for (n = 0; n < phase_items; n++) begin
        store_full = 1'b1;
        for (k = 0; k < rows_eff * cols_eff; k++) begin
          if (!written[k]) store_full = 1'b0;
        end
        if (!store_full || $urandom_range(1) == 0) begin
          case ($urandom_range(7))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            default: value = $urandom();
          endcase
          send_word(CMD_LOAD, value, ANGLE_W'($urandom_range(3)));
        end else begin
          send_word(CMD_ROTATE, $urandom(), ANGLE_W'($urandom_range(3)));
        end
      end
      no_idle = 1'b0;
    end
    settle();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mqr_pkg.sv
design/mqr_ram.sv
design/mqr_ctrl.sv
design/mqr_datapath.sv
design/matrix_quarter_turn_rotator.sv
tb/mqr_rotation_checker.sv
tb/tb_matrix_quarter_turn_rotator.sv
